// File: hw/rtl/dense_matrix_multiply_defines.svh
// Assertion macros for the dense matrix multiplier.
// Used by dense_matrix_multiply.sv; the including module has clk and arst_n in scope.
`ifndef DENSE_MATRIX_MULTIPLY_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define DMM_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its trigger.
`define DMM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/dmm_pkg.sv
// Types, constants and the microcode table of the dense matrix multiplier.
// No dependencies; imported by dense_matrix_multiply.sv.
package dmm_pkg;

	localparam int MAX_DIM  = 8;
	localparam int IDX_W    = $clog2(MAX_DIM);
	localparam int DIM_W    = $clog2(MAX_DIM + 1);
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int DEPTH    = MAX_DIM * MAX_DIM;
	localparam int DATA_W   = 32;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = 2 * DATA_W - FRAC_W;
	localparam int ACC_W    = PROD_W + $clog2(MAX_DIM) + 1;
	localparam int CFG_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W     = 2;

	localparam int S_TDATA_W = ((2 * IDX_W + DATA_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 * IDX_W + DATA_W + 7) / 8) * 8;
	localparam int M_TUSER_W = 2;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_WR_A    = 2'd0,
		OP_WR_B    = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_A_ROWS    = 2'd0,
		CFG_INNER_DIM = 2'd1,
		CFG_B_COLS    = 2'd2
	} cfg_idx_t;

	// Microcode addresses.
	typedef enum logic [3:0] {
		U_IDLE   = 4'd0,
		U_ERR    = 4'd1,
		U_START  = 4'd2,
		U_CELL   = 4'd3,
		U_RD     = 4'd4,
		U_DRAIN1 = 4'd5,
		U_DRAIN2 = 4'd6,
		U_EMIT   = 4'd7,
		U_DONE   = 4'd8
	} uaddr_t;

	// Branch conditions: taken means jump to target, else fall through.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_DISPATCH,
		C_K_MORE,
		C_NOT_LAST
	} ucond_t;

	typedef struct packed {
		logic   ready;    // take an input item
		logic   rd;       // read A[i][k] and B[k][j]
		logic   clr_ij;   // restart the result walk
		logic   clr_cell; // clear k and the accumulator
		logic   inc_k;
		logic   step_ij;  // advance column, wrap into next row
		logic   emit;     // load the output register
		logic   err;      // emit the error payload
		logic   hold;     // wait while the output register is full
		ucond_t cond;
		uaddr_t target;
	} uword_t;

	function automatic uword_t ucode_rom(uaddr_t a);
		uword_t w;
		w = '0;
		w.cond   = C_NEVER;
		w.target = U_IDLE;
		unique case (a)
			U_IDLE: begin
				w.ready = 1'b1;
				w.cond  = C_DISPATCH;
			end
			U_ERR: begin
				w.emit   = 1'b1;
				w.err    = 1'b1;
				w.hold   = 1'b1;
				w.cond   = C_ALWAYS;
				w.target = U_IDLE;
			end
			U_START: w.clr_ij = 1'b1;
			U_CELL:  w.clr_cell = 1'b1;
			U_RD: begin
				w.rd     = 1'b1;
				w.inc_k  = 1'b1;
				w.cond   = C_K_MORE;
				w.target = U_RD;
			end
			U_DRAIN1: w.cond = C_NEVER;
			U_DRAIN2: w.cond = C_NEVER;
			U_EMIT: begin
				w.emit    = 1'b1;
				w.hold    = 1'b1;
				w.step_ij = 1'b1;
				w.cond    = C_NOT_LAST;
				w.target  = U_CELL;
			end
			U_DONE: begin
				w.cond   = C_ALWAYS;
				w.target = U_IDLE;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = U_IDLE;
			end
		endcase
		return w;
	endfunction

	// Register value 0 acts as 1, values above MAX_DIM as MAX_DIM.
	function automatic logic [DIM_W-1:0] eff_dim(logic [CFG_W-1:0] r);
		logic [DIM_W-1:0] d;
		if (r == '0) begin
			d = DIM_W'(1);
		end else if (r > CFG_W'(MAX_DIM)) begin
			d = DIM_W'(MAX_DIM);
		end else begin
			d = DIM_W'(r);
		end
		return d;
	endfunction

endpackage

// File: hw/rtl/dense_matrix_multiply.sv
// Dense matrix multiplier, signed Q16.16, driven by a microcoded sequencer.
// Depends on dmm_pkg.sv and dense_matrix_multiply_defines.svh.
//
// Usage:
//   Input stream (s_axis_*): tuser carries the op code, tdata the row and column
//   index and the element value. Op 0 writes an element of A, op 1 an element
//   of B, op 2 starts a multiply, op 3 is dropped. A write gives no result
//   unless its index is outside the configured size; then one error item
//   (status 1, last 1) is sent and nothing is stored.
//   Output stream (m_axis_*): C = A * B in row-major order, one item per
//   element, tlast on the final one. tuser flags saturation and error.
//   Config port: cfg_we/cfg_addr/cfg_wdata set a_rows, inner_dim and b_cols;
//   write only while the block is idle.
// Sequence: a multiply holds off input from the accept until the run ends, a pace
//   set by the single shared multiply-accumulate unit and one read port per
//   store; each element costs a cell setup, n reads, two pipeline drain steps
//   and an emit, and the run ends with a done step.
// Reset: sequencer idle, sizes 8x8x8, output empty; store contents undefined.
// Stall: when the receiver holds tready low the sequencer waits at its emit
//   step; the output register holds the item until it is taken.
module dense_matrix_multiply (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [2:0] row_index, [5:3] col_index, [37:6] element_value, rest zero
	input  logic [dmm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [dmm_pkg::OP_W-1:0]          s_axis_tuser,
	// master side
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [2:0] out_row, [5:3] out_col, [37:6] out_value, rest zero
	output logic [dmm_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// [0] saturated, [1] status
	output logic [dmm_pkg::M_TUSER_W-1:0]     m_axis_tuser,
	output logic                              m_axis_tlast,
	// configuration
	input  logic                              cfg_we,
	input  logic [dmm_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [dmm_pkg::CFG_W-1:0]         cfg_wdata
);
	import dmm_pkg::*;

	// ---------------------------------------------------------------- config
	logic [CFG_W-1:0] a_rows_q, inner_dim_q, b_cols_q;
	logic [DIM_W-1:0] m_eff, n_eff, p_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= CFG_W'(MAX_DIM);
			inner_dim_q <= CFG_W'(MAX_DIM);
			b_cols_q    <= CFG_W'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_A_ROWS:    a_rows_q    <= cfg_wdata;
				CFG_INNER_DIM: inner_dim_q <= cfg_wdata;
				CFG_B_COLS:    b_cols_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign m_eff = eff_dim(a_rows_q);
	assign n_eff = eff_dim(inner_dim_q);
	assign p_eff = eff_dim(b_cols_q);

	// ---------------------------------------------------------------- input
	logic [IDX_W-1:0]  in_row, in_col;
	logic [DATA_W-1:0] in_value;
	logic              in_acc;
	logic              in_range;
	logic [DIM_W-1:0]  row_lim, col_lim;
	logic              is_wr_a, is_wr_b, is_compute;

	assign in_row   = s_axis_tdata[IDX_W-1:0];
	assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
	assign in_value = s_axis_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

	assign is_wr_a    = (op_t'(s_axis_tuser) == OP_WR_A);
	assign is_wr_b    = (op_t'(s_axis_tuser) == OP_WR_B);
	assign is_compute = (op_t'(s_axis_tuser) == OP_COMPUTE);

	// A is m x n, B is n x p
	assign row_lim  = is_wr_a ? m_eff : n_eff;
	assign col_lim  = is_wr_a ? n_eff : p_eff;
	assign in_range = (DIM_W'(in_row) < row_lim) && (DIM_W'(in_col) < col_lim);

	// ---------------------------------------------------------------- sequencer
	uaddr_t upc_q, upc_d;
	uword_t uw;
	logic   stall;
	logic   cond_hit;
	logic   load_out;
	logic   rd_en;

	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             i_last, j_last, k_last;

	assign uw            = ucode_rom(upc_q);
	assign s_axis_tready = uw.ready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign i_last = (DIM_W'(i_q) == m_eff - DIM_W'(1));
	assign j_last = (DIM_W'(j_q) == p_eff - DIM_W'(1));
	assign k_last = (DIM_W'(k_q) == n_eff - DIM_W'(1));

	// hold the emit step while the output register is still full
	assign stall    = uw.hold && m_axis_tvalid && !m_axis_tready;
	assign load_out = uw.emit && !stall;
	assign rd_en    = uw.rd && !stall;

	always_comb begin
		unique case (uw.cond)
			C_NEVER:    cond_hit = 1'b0;
			C_ALWAYS:   cond_hit = 1'b1;
			C_K_MORE:   cond_hit = !k_last;
			C_NOT_LAST: cond_hit = !(i_last && j_last);
			C_DISPATCH: cond_hit = 1'b0;
			default:    cond_hit = 1'b0;
		endcase

		if (stall) begin
			upc_d = upc_q;
		end else if (uw.cond == C_DISPATCH) begin
			priority if (in_acc && is_compute) begin
				upc_d = U_START;
			end else if (in_acc && (is_wr_a || is_wr_b) && !in_range) begin
				upc_d = U_ERR;
			end else begin
				upc_d = U_IDLE;
			end
		end else if (cond_hit) begin
			upc_d = uw.target;
		end else begin
			upc_d = uaddr_t'(upc_q + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (!stall) begin
			if (uw.clr_ij) begin
				i_q <= '0;
				j_q <= '0;
			end else if (uw.step_ij) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			if (uw.clr_cell) begin
				k_q <= '0;
			end else if (uw.inc_k) begin
				k_q <= k_q + IDX_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------- stores
	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];
	logic [DATA_W-1:0] rd_a_s1, rd_b_s1;
	logic              wr_a, wr_b;

	assign wr_a = in_acc && is_wr_a && in_range;
	assign wr_b = in_acc && is_wr_b && in_range;

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[{in_row, in_col}] <= in_value;
		end
		if (rd_en) begin
			rd_a_s1 <= mem_a[{i_q, k_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[{in_row, in_col}] <= in_value;
		end
		if (rd_en) begin
			rd_b_s1 <= mem_b[{k_q, j_q}];
		end
	end

	// ---------------------------------------------------------------- MAC
	logic                     rd_vld_s1, mul_vld_s2;
	logic signed [2*DATA_W-1:0] mul_full;
	logic [PROD_W-1:0]        prod_s2;
	logic [ACC_W-1:0]         acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1  <= rd_en;
			mul_vld_s2 <= rd_vld_s1;
		end
	end

	assign mul_full = $signed(rd_a_s1) * $signed(rd_b_s1);

	// drop the low fraction bits: arithmetic shift, floor toward minus infinity
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			prod_s2 <= mul_full[2*DATA_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (uw.clr_cell && !stall) begin
			acc_q <= '0;
		end else if (mul_vld_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	// saturate to 32 bits: all bits above the 32-bit sign must match it
	logic [ACC_W-DATA_W:0] acc_hi;
	logic                  acc_sat;
	logic [DATA_W-1:0]     acc_clip;

	assign acc_hi   = acc_q[ACC_W-1:DATA_W-1];
	assign acc_sat  = !((&acc_hi) || !(|acc_hi));
	assign acc_clip = acc_sat ? (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX) : acc_q[DATA_W-1:0];

	// ---------------------------------------------------------------- output
	logic              out_vld_q;
	logic [IDX_W-1:0]  out_row_q, out_col_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_sat_q, out_status_q, out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (uw.err) begin
				out_row_q    <= '0;
				out_col_q    <= '0;
				out_value_q  <= '0;
				out_sat_q    <= 1'b0;
				out_status_q <= 1'b1;
				out_last_q   <= 1'b1;
			end else begin
				out_row_q    <= i_q;
				out_col_q    <= j_q;
				out_value_q  <= acc_clip;
				out_sat_q    <= acc_sat;
				out_status_q <= 1'b0;
				out_last_q   <= i_last && j_last;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(M_TDATA_W-2*IDX_W-DATA_W){1'b0}}, out_value_q, out_col_q, out_row_q};
	assign m_axis_tuser  = {out_status_q, out_sat_q};
	assign m_axis_tlast  = out_last_q;

	// ---------------------------------------------------------------- checks
	`include "dense_matrix_multiply_defines.svh"

	`DMM_ASSERT_SAME(a_idle_pipe_empty, upc_q == U_IDLE, !rd_vld_s1 && !mul_vld_s2, "MAC pipeline busy while idle")
	`DMM_ASSERT_SAME(a_emit_drained, load_out && !uw.err, !rd_vld_s1 && !mul_vld_s2, "emit before accumulation finished")
	`DMM_ASSERT_SAME(a_k_in_range, rd_en, DIM_W'(k_q) < n_eff, "inner index past inner_dim")
	`DMM_ASSERT_NEXT(a_last_ends_run, load_out && !uw.err && i_last && j_last, upc_q == U_DONE, "run did not end after last element")

endmodule
